[sv/bsm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants of the box distance sphere marcher: field widths,
// register indexes and reset values, and the link that runs along the cells.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int DEPTH_W   = 32;              // Q16.16 depth and coordinates
    localparam int DIR_W     = 16;              // Q2.14 direction component
    localparam int PROD_W    = DEPTH_W + DIR_W; // exact dir*depth product
    localparam int PSH_W     = PROD_W - 14;     // product back in Q16.16
    localparam int DIFF_W    = 36;              // point minus center
    localparam int DIST_W    = DIFF_W + 1;      // signed axis distance
    localparam int SIDE_W    = 31;
    localparam int HALF_W    = SIDE_W - 1;
    localparam int EPS_W     = 17;
    localparam int NUM_AXES  = 3;
    localparam int MAX_STEPS_DEF = 64;

    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_SIDE     = 3'd3,
        REG_EPSILON  = 3'd4
    } t_reg_idx;

    localparam logic signed [DEPTH_W-1:0] CENTER_RST  = '0;
    localparam logic        [SIDE_W-1:0]  SIDE_RST    = SIDE_W'(32768);
    localparam logic        [EPS_W-1:0]   EPSILON_RST = EPS_W'(66);

    // Lowest distance code; any real axis distance is above it.
    localparam logic signed [DIST_W-1:0] DIST_FLOOR = {1'b1, {(DIST_W-1){1'b0}}};

    typedef struct packed {
        logic                       vld;
        logic signed [DEPTH_W-1:0]  depth;
        logic signed [DIST_W-1:0]   dmax;
    } t_link;

endpackage
`default_nettype wire

[sv/box_sdf_sphere_march_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// box_sdf_sphere_march_core
// Sphere traces one ray against an axis-aligned cube held in configuration.
// A row of three axis cells forms the box distance; the step controller here
// adds it to the depth and decides between hit, miss and the next step.
//
//   channel   direction  handshake                    payload
//   ray in    input      i_valid / o_ready            origin, dir, start/end depth
//   result    output     o_valid / i_ready            hit_depth
//   config    input      psel penable pwrite pready   paddr, pwdata, prdata
//
// One march step passes through a launch register and three stages in each
// of the three cells. A ray runs 1..MAX_STEPS steps; its result moves into the
// output register once that register is free, and the next ray is taken after.
// The result sits in an output register, so a new ray may be marching while
// the last result waits. Reset is synchronous and restores the register values.
// ----------------------------------------------------------------------------
module box_sdf_sphere_march_core
    import bsm_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire logic signed [DEPTH_W-1:0] i_origin_x,
    input  wire logic signed [DEPTH_W-1:0] i_origin_y,
    input  wire logic signed [DEPTH_W-1:0] i_origin_z,
    input  wire logic signed [DIR_W-1:0]   i_dir_x,
    input  wire logic signed [DIR_W-1:0]   i_dir_y,
    input  wire logic signed [DIR_W-1:0]   i_dir_z,
    input  wire logic signed [DEPTH_W-1:0] i_start_depth,
    input  wire logic signed [DEPTH_W-1:0] i_end_depth,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic signed [DEPTH_W-1:0]    o_hit_depth,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire logic [ADDR_W-1:0]       paddr,
    input  wire logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]            prdata,
    output logic                         pready
);

    localparam int CNT_W = $clog2(MAX_STEPS + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    // Configuration registers.
    logic signed [DEPTH_W-1:0] r_ctr [NUM_AXES];
    logic        [SIDE_W-1:0]  r_side;
    logic        [EPS_W-1:0]   r_eps;
    logic                      w_wr;
    t_reg_idx                  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr[0] <= CENTER_RST;
            r_ctr[1] <= CENTER_RST;
            r_ctr[2] <= CENTER_RST;
            r_side   <= SIDE_RST;
            r_eps    <= EPSILON_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_CENTER_X: r_ctr[0] <= pwdata;
                REG_CENTER_Y: r_ctr[1] <= pwdata;
                REG_CENTER_Z: r_ctr[2] <= pwdata;
                REG_SIDE:     r_side   <= pwdata[SIDE_W-1:0];
                REG_EPSILON:  r_eps    <= pwdata[EPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CENTER_X: prdata = r_ctr[0];
            REG_CENTER_Y: prdata = r_ctr[1];
            REG_CENTER_Z: prdata = r_ctr[2];
            REG_SIDE:     prdata = DATA_W'(r_side);
            REG_EPSILON:  prdata = DATA_W'(r_eps);
            default:      prdata = '0;
        endcase
    end

    // Cell row.
    logic                      w_accept;
    t_link                     w_link [NUM_AXES+1];
    logic signed [DEPTH_W-1:0] w_org  [NUM_AXES];
    logic signed [DIR_W-1:0]   w_dir  [NUM_AXES];
    t_link                     r_launch, n_launch;

    assign w_accept  = i_valid & o_ready;
    assign w_org[0]  = i_origin_x;
    assign w_org[1]  = i_origin_y;
    assign w_org[2]  = i_origin_z;
    assign w_dir[0]  = i_dir_x;
    assign w_dir[1]  = i_dir_y;
    assign w_dir[2]  = i_dir_z;
    assign w_link[0] = r_launch;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_cell
        bsm_axis_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_accept),
            .i_org   (w_org[g]),
            .i_dir   (w_dir[g]),
            .i_ctr   (r_ctr[g]),
            .i_half  (r_side[SIDE_W-1:1]),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    // Step controller.
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_step, n_step;
    logic signed [DEPTH_W-1:0] r_depth, n_depth;
    logic signed [DEPTH_W-1:0] r_end, n_end;
    logic signed [DEPTH_W-1:0] r_result, n_result;
    logic                      r_ovld, n_ovld;
    logic signed [DEPTH_W-1:0] r_odata, n_odata;

    t_link                     w_tail;
    logic                      w_hit;
    logic signed [DEPTH_W+6:0] w_sum;
    logic signed [DEPTH_W-1:0] w_next;

    assign w_tail = w_link[NUM_AXES];
    assign w_hit  = w_tail.dmax < $signed(DIST_W'(r_eps));
    assign w_sum  = (DEPTH_W+7)'(r_depth) + (DEPTH_W+7)'(w_tail.dmax);

    always_comb begin
        if (w_sum > (DEPTH_W+7)'(signed'({1'b0, {(DEPTH_W-1){1'b1}}}))) begin
            w_next = {1'b0, {(DEPTH_W-1){1'b1}}};
        end else if (w_sum < (DEPTH_W+7)'(signed'({1'b1, {(DEPTH_W-1){1'b0}}}))) begin
            w_next = {1'b1, {(DEPTH_W-1){1'b0}}};
        end else begin
            w_next = w_sum[DEPTH_W-1:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_depth  = r_depth;
        n_end    = r_end;
        n_result = r_result;
        n_launch = '{vld: 1'b0, depth: r_depth, dmax: DIST_FLOOR};
        n_ovld   = r_ovld & ~i_ready;
        n_odata  = r_odata;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state  = S_RUN;
                    n_step   = '0;
                    n_depth  = i_start_depth;
                    n_end    = i_end_depth;
                    n_launch = '{vld: 1'b1, depth: i_start_depth, dmax: DIST_FLOOR};
                end
            end
            S_RUN: begin
                if (w_tail.vld) begin
                    if (w_hit) begin
                        n_result = r_depth;
                        n_state  = S_DONE;
                    end else if (w_next >= r_end || r_step == CNT_W'(MAX_STEPS - 1)) begin
                        n_result = r_end;
                        n_state  = S_DONE;
                    end else begin
                        n_step   = r_step + CNT_W'(1);
                        n_depth  = w_next;
                        n_launch = '{vld: 1'b1, depth: w_next, dmax: DIST_FLOOR};
                    end
                end
            end
            S_DONE: begin
                // Wait for the output register to drain before handing over.
                if (!r_ovld || i_ready) begin
                    n_ovld  = 1'b1;
                    n_odata = r_result;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_depth        <= n_depth;
        r_end          <= n_end;
        r_result       <= n_result;
        r_odata        <= n_odata;
        r_launch.depth <= n_launch.depth;
        r_launch.dmax  <= n_launch.dmax;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_launch.vld <= 1'b0;
            r_ovld       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_launch.vld <= n_launch.vld;
            r_ovld       <= n_ovld;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_ovld;
    assign o_hit_depth = r_odata;

    // A distance only comes out of the cell row while a ray is marching.
    a_tail_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.vld |-> (r_state == S_RUN))
        else $error("cell row produced a distance outside a march");

    // An accepted ray always starts a step in the cell row.
    a_accept_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_launch.vld && r_state == S_RUN))
        else $error("accepted ray did not launch a step");

    // The step count stays within the configured limit.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_step <= CNT_W'(MAX_STEPS - 1)))
        else $error("step counter ran past the limit");

    // A finished ray never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !i_ready) |=> (r_ovld && $stable(r_odata)))
        else $error("pending result was overwritten");

endmodule
`default_nettype wire

[sv/bsm_axis_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_axis_cell
// One axis of the box distance. Holds the ray's origin and direction for its
// axis, evaluates |origin + dir*depth - center| - side/2 in three stages and
// passes the running maximum and the depth to the next cell.
// ----------------------------------------------------------------------------
module bsm_axis_cell
    import bsm_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_load,
    input  wire logic signed [DEPTH_W-1:0] i_org,
    input  wire logic signed [DIR_W-1:0]   i_dir,
    input  wire logic signed [DEPTH_W-1:0] i_ctr,
    input  wire logic        [HALF_W-1:0]  i_half,
    input  wire t_link                i_link,
    output t_link                     o_link
);

    logic signed [DEPTH_W-1:0] r_org;
    logic signed [DIR_W-1:0]   r_dir;

    logic                      r_vld1, r_vld2;
    logic signed [DEPTH_W-1:0] r_depth1, r_depth2;
    logic signed [DIST_W-1:0]  r_max1, r_max2;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [DIFF_W-1:0]  r_diff;
    t_link                     r_out;

    logic signed [PSH_W-1:0]   w_psh;
    logic signed [DIFF_W-1:0]  n_diff;
    logic        [DIFF_W-1:0]  w_abs;
    logic signed [DIST_W-1:0]  w_dist;
    t_link                     n_out;

    // The arithmetic shift floors the product toward minus infinity.
    assign w_psh  = PSH_W'(r_prod >>> 14);
    assign n_diff = DIFF_W'(r_org) + DIFF_W'(w_psh) - DIFF_W'(i_ctr);
    assign w_abs  = r_diff[DIFF_W-1] ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);
    assign w_dist = $signed({1'b0, w_abs}) - $signed(DIST_W'(i_half));

    always_comb begin
        n_out.vld   = r_vld2;
        n_out.depth = r_depth2;
        n_out.dmax  = (w_dist > r_max2) ? w_dist : r_max2;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_org <= i_org;
            r_dir <= i_dir;
        end
        r_prod   <= r_dir * i_link.depth;
        r_depth1 <= i_link.depth;
        r_max1   <= i_link.dmax;
        r_diff   <= n_diff;
        r_depth2 <= r_depth1;
        r_max2   <= r_max1;
        r_out.depth <= n_out.depth;
        r_out.dmax  <= n_out.dmax;
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_out.vld <= 1'b0;
        end else begin
            r_vld1    <= i_link.vld;
            r_vld2    <= r_vld1;
            r_out.vld <= n_out.vld;
        end
    end

    assign o_link = r_out;

endmodule
`default_nettype wire

[bench/box_sdf_sphere_march_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_sdf_sphere_march_checker
// Watches the ray, result and register ports of the sphere marcher. It keeps
// its own copy of the cube registers and marches every accepted ray in
// software. Each returned hit depth is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module box_sdf_sphere_march_checker
    import bsm_pkg::*;
#(
    parameter int STEPS = MAX_STEPS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_ray_valid,
    input  wire                            i_ray_ready,
    input  wire logic signed [DEPTH_W-1:0] i_origin_x,
    input  wire logic signed [DEPTH_W-1:0] i_origin_y,
    input  wire logic signed [DEPTH_W-1:0] i_origin_z,
    input  wire logic signed [DIR_W-1:0]   i_dir_x,
    input  wire logic signed [DIR_W-1:0]   i_dir_y,
    input  wire logic signed [DIR_W-1:0]   i_dir_z,
    input  wire logic signed [DEPTH_W-1:0] i_start_depth,
    input  wire logic signed [DEPTH_W-1:0] i_end_depth,
    input  wire                            i_res_valid,
    input  wire                            i_res_ready,
    input  wire logic signed [DEPTH_W-1:0] i_hit_depth,
    input  wire                            i_psel,
    input  wire                            i_penable,
    input  wire                            i_pwrite,
    input  wire                            i_pready,
    input  wire logic [ADDR_W-1:0]         i_paddr,
    input  wire logic [DATA_W-1:0]         i_pwdata,
    output int                             o_mismatches,
    output int                             o_outstanding
);

    localparam longint DEPTH_HI   = 64'sd2147483647;
    localparam longint DEPTH_LO   = -64'sd2147483648;
    localparam int     REPORT_CAP = 100;

    longint box_cx = 0;
    longint box_cy = 0;
    longint box_cz = 0;
    longint box_side_q = 0;
    longint hit_eps = 0;

    logic signed [DEPTH_W-1:0] expected_hit_depths[$];
    logic signed [DEPTH_W-1:0] oldest_hit_depth;
    int mismatch_count = 0;
    int pending_rays = 0;

    assign o_mismatches  = mismatch_count;
    assign o_outstanding = pending_rays;

    task automatic report(input string what);
        // Past the cap, mismatches are only counted.
        if (mismatch_count < REPORT_CAP) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Appends one prediction behind the ones still waiting for their result.
    task automatic queue_prediction(input logic signed [DEPTH_W-1:0] depth);
        expected_hit_depths.insert(expected_hit_depths.size(), depth);
    endtask

    // Signed distance of the point on the ray from the slab of one axis.
    function automatic longint axis_gap(input longint org, input longint dir,
                                        input longint depth, input longint ctr);
        longint pos;
        pos = org + ((dir * depth) >>> 14) - ctr;
        if (pos < 0) begin
            pos = -pos;
        end
        return pos - (box_side_q >>> 1);
    endfunction

    function automatic logic signed [DEPTH_W-1:0] predict_hit_depth(
        input longint ox, input longint oy, input longint oz,
        input longint dx, input longint dy, input longint dz,
        input longint first, input longint last);
        longint depth;
        longint gap;
        longint axis;
        logic   done;
        logic signed [DEPTH_W-1:0] hit;
        depth = first;
        hit   = DEPTH_W'(last);
        done  = 1'b0;
        for (int step = 0; step < STEPS && !done; step++) begin
            gap  = axis_gap(ox, dx, depth, box_cx);
            axis = axis_gap(oy, dy, depth, box_cy);
            if (axis > gap) begin
                gap = axis;
            end
            axis = axis_gap(oz, dz, depth, box_cz);
            if (axis > gap) begin
                gap = axis;
            end
            if (gap < hit_eps) begin
                hit  = DEPTH_W'(depth);
                done = 1'b1;
            end else begin
                depth = depth + gap;
                if (depth > DEPTH_HI) begin
                    depth = DEPTH_HI;
                end
                if (depth < DEPTH_LO) begin
                    depth = DEPTH_LO;
                end
                // The end test only follows a step that missed.
                if (depth >= last) begin
                    done = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            box_cx     = longint'(CENTER_RST);
            box_cy     = longint'(CENTER_RST);
            box_cz     = longint'(CENTER_RST);
            box_side_q = longint'(SIDE_RST);
            hit_eps    = longint'(EPSILON_RST);
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_hit_depths.size() == 0) begin
                    report($sformatf("hit depth 0x%08h with no ray pending", i_hit_depth));
                end else begin
                    oldest_hit_depth = expected_hit_depths.pop_front();
                    if (i_hit_depth !== oldest_hit_depth) begin
                        report($sformatf("hit depth 0x%08h, predicted 0x%08h",
                                         i_hit_depth, oldest_hit_depth));
                    end
                end
            end
            if (i_ray_valid && i_ray_ready) begin
                queue_prediction(predict_hit_depth(
                    longint'(i_origin_x), longint'(i_origin_y), longint'(i_origin_z),
                    longint'(i_dir_x), longint'(i_dir_y), longint'(i_dir_z),
                    longint'(i_start_depth), longint'(i_end_depth)));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_CENTER_X: box_cx = longint'($signed(i_pwdata));
                    REG_CENTER_Y: box_cy = longint'($signed(i_pwdata));
                    REG_CENTER_Z: box_cz = longint'($signed(i_pwdata));
                    REG_SIDE:     box_side_q = longint'(i_pwdata[SIDE_W-1:0]);
                    REG_EPSILON:  hit_eps = longint'(i_pwdata[EPS_W-1:0]);
                    default: ;
                endcase
            end
        end
        pending_rays = expected_hit_depths.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Ray stimulus for the box distance sphere marcher. A directed set covers hits,
// misses, rays that run out of steps, saturating depths and register masking;
// then random phases under changing cube settings and idle patterns. The
// checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import bsm_pkg::*;

    localparam int RAYS_PER_PHASE = 330;
    localparam int NUM_PHASES     = 6;

    localparam logic signed [DEPTH_W-1:0] Q_ONE     = 32'sh0001_0000;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
    localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
    localparam logic signed [DIR_W-1:0]   DIR_ONE   = 16'sh4000;
    localparam logic signed [DIR_W-1:0]   DIR_MAX   = 16'sh7FFF;
    localparam logic signed [DIR_W-1:0]   DIR_MIN   = 16'sh8000;
    localparam logic signed [DIR_W-1:0]   DIR_LSB   = 16'sh0001;
    localparam logic signed [DIR_W-1:0]   DIR_DIAG  = 16'sd9459;  // 1/sqrt(3)

    typedef struct {
        logic signed [DEPTH_W-1:0] org_x;
        logic signed [DEPTH_W-1:0] org_y;
        logic signed [DEPTH_W-1:0] org_z;
        logic signed [DIR_W-1:0]   dir_x;
        logic signed [DIR_W-1:0]   dir_y;
        logic signed [DIR_W-1:0]   dir_z;
        logic signed [DEPTH_W-1:0] start_depth;
        logic signed [DEPTH_W-1:0] end_depth;
    } t_ray;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    logic signed [DEPTH_W-1:0] i_origin_x;
    logic signed [DEPTH_W-1:0] i_origin_y;
    logic signed [DEPTH_W-1:0] i_origin_z;
    logic signed [DIR_W-1:0]   i_dir_x;
    logic signed [DIR_W-1:0]   i_dir_y;
    logic signed [DIR_W-1:0]   i_dir_z;
    logic signed [DEPTH_W-1:0] i_start_depth;
    logic signed [DEPTH_W-1:0] i_end_depth;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [DEPTH_W-1:0] o_hit_depth;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    int mismatches;
    int outstanding;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    longint cfg_cx = 0;
    longint cfg_cy = 0;
    longint cfg_cz = 0;

    box_sdf_sphere_march_core #(
        .MAX_STEPS (MAX_STEPS_DEF)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_origin_z    (i_origin_z),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .i_start_depth (i_start_depth),
        .i_end_depth   (i_end_depth),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_hit_depth   (o_hit_depth),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    box_sdf_sphere_march_checker #(
        .STEPS (MAX_STEPS_DEF)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ray_valid   (i_valid),
        .i_ray_ready   (o_ready),
        .i_origin_x    (i_origin_x),
        .i_origin_y    (i_origin_y),
        .i_origin_z    (i_origin_z),
        .i_dir_x       (i_dir_x),
        .i_dir_y       (i_dir_y),
        .i_dir_z       (i_dir_z),
        .i_start_depth (i_start_depth),
        .i_end_depth   (i_end_depth),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_hit_depth   (o_hit_depth),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    initial begin
        #(100_000_000);
        $display("box_sdf_sphere_march_core verification failed");
        $finish;
    end

    function automatic logic signed [DEPTH_W-1:0] q16(input int units);
        return DEPTH_W'(units * 65536);
    endfunction

    function automatic logic [ADDR_W-1:0] reg_addr(input t_reg_idx idx);
        return ADDR_W'(idx) << 2;
    endfunction

    function automatic t_ray make_ray(
        input logic signed [DEPTH_W-1:0] ox, input logic signed [DEPTH_W-1:0] oy,
        input logic signed [DEPTH_W-1:0] oz, input logic signed [DIR_W-1:0] dx,
        input logic signed [DIR_W-1:0] dy, input logic signed [DIR_W-1:0] dz,
        input logic signed [DEPTH_W-1:0] first, input logic signed [DEPTH_W-1:0] last);
        t_ray r;
        r.org_x = ox;
        r.org_y = oy;
        r.org_z = oz;
        r.dir_x = dx;
        r.dir_y = dy;
        r.dir_z = dz;
        r.start_depth = first;
        r.end_depth   = last;
        return r;
    endfunction

    function automatic real rand_span(input real span);
        return ($urandom_range(0, 2_000_000) / 1_000_000.0 - 1.0) * span;
    endfunction

    function automatic logic signed [DIR_W-1:0] unit_dir_comp();
        return DIR_W'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    // Most rays start near the cube and point roughly at it; the rest are noise.
    function automatic t_ray random_ray();
        t_ray r;
        real off_x, off_y, off_z;
        real aim_x, aim_y, aim_z;
        real len;
        if ($urandom_range(99) < 20) begin
            r.org_x = $urandom;
            r.org_y = $urandom;
            r.org_z = $urandom;
            r.dir_x = $urandom_range(1) ? DIR_W'($urandom) : unit_dir_comp();
            r.dir_y = $urandom_range(1) ? DIR_W'($urandom) : unit_dir_comp();
            r.dir_z = $urandom_range(1) ? DIR_W'($urandom) : unit_dir_comp();
            r.start_depth = $urandom;
            r.end_depth   = $urandom;
            return r;
        end
        off_x = rand_span(12.0);
        off_y = rand_span(12.0);
        off_z = rand_span(12.0);
        aim_x = rand_span(1.5) - off_x;
        aim_y = rand_span(1.5) - off_y;
        aim_z = rand_span(1.5) - off_z;
        len = $sqrt(aim_x * aim_x + aim_y * aim_y + aim_z * aim_z);
        if (len < 1.0e-6) begin
            aim_x = 1.0;
            len   = 1.0;
        end
        r.org_x = DEPTH_W'(cfg_cx + longint'($rtoi(off_x * 65536.0)));
        r.org_y = DEPTH_W'(cfg_cy + longint'($rtoi(off_y * 65536.0)));
        r.org_z = DEPTH_W'(cfg_cz + longint'($rtoi(off_z * 65536.0)));
        r.dir_x = DIR_W'($rtoi(aim_x / len * 16384.0));
        r.dir_y = DIR_W'($rtoi(aim_y / len * 16384.0));
        r.dir_z = DIR_W'($rtoi(aim_z / len * 16384.0));
        r.start_depth = DEPTH_W'($rtoi(rand_span(2.0) * 65536.0));
        if ($urandom_range(9) == 0) begin
            r.end_depth = r.start_depth - DEPTH_W'($urandom_range(0, 4 * 65536));
        end else begin
            r.end_depth = r.start_depth + DEPTH_W'($urandom_range(0, 40 * 65536));
        end
        return r;
    endfunction

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_cube(input logic [DATA_W-1:0] cx, input logic [DATA_W-1:0] cy,
                              input logic [DATA_W-1:0] cz, input logic [DATA_W-1:0] side,
                              input logic [DATA_W-1:0] eps);
        apb_write(reg_addr(REG_CENTER_X), cx);
        apb_write(reg_addr(REG_CENTER_Y), cy);
        apb_write(reg_addr(REG_CENTER_Z), cz);
        apb_write(reg_addr(REG_SIDE), side);
        apb_write(reg_addr(REG_EPSILON), eps);
        cfg_cx = longint'($signed(cx));
        cfg_cy = longint'($signed(cy));
        cfg_cz = longint'($signed(cz));
    endtask

    function automatic logic [DATA_W-1:0] random_center();
        if ($urandom_range(3) == 0) begin
            return $urandom;
        end
        return DATA_W'($signed($urandom_range(0, 32 * 65536)) - 16 * 65536);
    endfunction

    task automatic random_cube(input int phase);
        logic [DATA_W-1:0] side;
        logic [DATA_W-1:0] eps;
        // Bits above each register's width are junk that the block must drop.
        case (phase)
            4:       side = $urandom & 32'h8000_0000;
            5:       side = $urandom | 32'h7FFF_FFFF;
            default: side = $urandom_range(16384, 8 * 65536) | ($urandom & 32'h8000_0000);
        endcase
        case (phase)
            2:       eps = $urandom & 32'hFFFE_0000;
            3:       eps = 32'h0001_0000;
            default: eps = $urandom_range(0, 4096) | ($urandom & 32'hFFFE_0000);
        endcase
        write_cube(random_center(), random_center(), random_center(), side, eps);
    endtask

    task automatic send_ray(input t_ray r);
        @(negedge i_clk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_origin_x    <= r.org_x;
        i_origin_y    <= r.org_y;
        i_origin_z    <= r.org_z;
        i_dir_x       <= r.dir_x;
        i_dir_y       <= r.dir_y;
        i_dir_z       <= r.dir_z;
        i_start_depth <= r.start_depth;
        i_end_depth   <= r.end_depth;
        i_valid       <= 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_origin_x    = '0;
        i_origin_y    = '0;
        i_origin_z    = '0;
        i_dir_x       = '0;
        i_dir_y       = '0;
        i_dir_z       = '0;
        i_start_depth = '0;
        i_end_depth   = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset cube: half-unit side at the origin.
        send_ray(make_ray(q16(-2), '0, '0, DIR_ONE, '0, '0, '0, q16(8)));
        send_ray(make_ray('0, '0, '0, '0, '0, DIR_ONE, '0, q16(8)));

        wait_drained();
        write_cube('0, '0, '0, q16(2), 32'd66);
        send_ray(make_ray(q16(-5), '0, '0, DIR_ONE, '0, '0, '0, q16(10)));
        send_ray(make_ray(q16(-5), '0, '0, -DIR_ONE, '0, '0, '0, q16(10)));
        // Start already past the end: one step still runs.
        send_ray(make_ray(q16(-5), '0, '0, DIR_ONE, '0, '0, q16(10), q16(2)));
        send_ray(make_ray(q16(-5), '0, '0, DIR_ONE, '0, '0, q16(4), q16(2)));
        // Skims a face just above epsilon until the steps run out.
        send_ray(make_ray(q16(-5), Q_ONE + 655, '0, DIR_ONE, '0, '0, '0, q16(10)));
        send_ray(make_ray(DEPTH_MAX, DEPTH_MAX, DEPTH_MAX, '0, '0, '0,
                          32'sh7FFF_0000, DEPTH_MAX));
        send_ray(make_ray('0, '0, '0, DIR_ONE, '0, '0, DEPTH_MIN, DEPTH_MIN));
        send_ray(make_ray('0, '0, '0, DIR_MIN, DIR_MAX, DIR_MIN, Q_ONE, q16(100)));
        send_ray(make_ray(q16(-5), '0, '0, '0, '0, '0, '0, q16(100)));
        send_ray(make_ray(DEPTH_MIN, DEPTH_MAX, DEPTH_MIN, DIR_ONE, -DIR_ONE, DIR_ONE,
                          DEPTH_MAX, DEPTH_MAX));
        send_ray(make_ray(q16(5), '0, '0, DIR_ONE, '0, '0, q16(-5), q16(10)));
        send_ray(make_ray(q16(-4), q16(-4), q16(-4), DIR_DIAG, DIR_DIAG, DIR_DIAG,
                          '0, q16(20)));

        // Odd side and zero epsilon: the product rounds toward minus infinity.
        wait_drained();
        write_cube('0, '0, '0, 32'h0002_0001, 32'hFFFE_0000);
        send_ray(make_ray(Q_ONE, '0, '0, -DIR_LSB, '0, '0, Q_ONE, q16(10)));
        send_ray(make_ray(q16(-5), '0, '0, DIR_ONE, '0, '0, '0, q16(10)));

        wait_drained();
        write_cube(DEPTH_MIN, DEPTH_MAX, DEPTH_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        apb_write(reg_addr(REG_EPSILON) + ADDR_W'(4), $urandom);
        apb_write({ADDR_W{1'b1}} & ~ADDR_W'(3), $urandom);
        send_ray(make_ray(DEPTH_MAX, DEPTH_MIN, DEPTH_MAX, DIR_MAX, DIR_MIN, DIR_MAX,
                          DEPTH_MIN, DEPTH_MAX));
        send_ray(make_ray('0, '0, '0, '0, '0, '0, '0, Q_ONE));
        send_ray(make_ray(DEPTH_MIN, DEPTH_MAX, DEPTH_MIN, '0, '0, '0, '0, DEPTH_MAX));

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            case (phase / 2)
                0: begin
                    tx_idle_pct = 35;
                    rx_idle_pct = 81;
                end
                1: begin
                    tx_idle_pct = 81;
                    rx_idle_pct = 35;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            random_cube(phase);
            for (int n = 0; n < RAYS_PER_PHASE; n++) begin
                if ($urandom_range(149) == 0) begin
                    wait_drained();
                end
                send_ray(random_ray());
            end
        end

        wait_drained();
        repeat (10 * MAX_STEPS_DEF + 20) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("box_sdf_sphere_march_core verification clean");
        end else begin
            $display("box_sdf_sphere_march_core verification failed");
        end
        $finish;
    end

endmodule
